// File: design/sldf_pkg.sv
`default_nettype none

package sldf_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CK_A    = 4'd7,
        PH_CK_B    = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] payload_len;
        logic [15:0] byte_pos;
    } t_result;

endpackage

`default_nettype wire

// File: design/sldf_byte_if.sv
`default_nettype none

interface sldf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// File: design/sldf_result_if.sv
`default_nettype none

interface sldf_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  data_byte;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_len;
    logic [15:0] byte_pos;

    modport source (output valid, output result_kind, output data_byte, output msg_class,
                    output msg_id, output payload_len, output byte_pos, input ready);
    modport sink   (input valid, input result_kind, input data_byte, input msg_class,
                    input msg_id, input payload_len, input byte_pos, output ready);
endinterface

`default_nettype wire

// File: design/sldf_parser.sv
`default_nettype none

module sldf_parser
    import sldf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire logic [7:0] i_byte,
    output logic            o_res_vld,
    output t_result         o_res
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [7:0]  r_class, n_class;
    logic [7:0]  r_id, n_id;
    logic [15:0] r_len, n_len;
    logic [15:0] r_count, n_count;
    logic        r_ck_a_ok, n_ck_a_ok;

    logic [7:0]  acc_a;
    logic [7:0]  acc_b;
    logic [15:0] count_inc;
    logic [15:0] len_full;

    assign acc_a     = r_sum_a + i_byte;
    assign acc_b     = r_sum_b + acc_a;
    assign count_inc = r_count + 16'd1;
    assign len_full  = {i_byte, r_len[7:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_sum_a   <= '0;
            r_sum_b   <= '0;
            r_class   <= '0;
            r_id      <= '0;
            r_len     <= '0;
            r_count   <= '0;
            r_ck_a_ok <= 1'b0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_sum_a   <= n_sum_a;
            r_sum_b   <= n_sum_b;
            r_class   <= n_class;
            r_id      <= n_id;
            r_len     <= n_len;
            r_count   <= n_count;
            r_ck_a_ok <= n_ck_a_ok;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_sum_a   = r_sum_a;
        n_sum_b   = r_sum_b;
        n_class   = r_class;
        n_id      = r_id;
        n_len     = r_len;
        n_count   = r_count;
        n_ck_a_ok = r_ck_a_ok;
        o_res_vld = 1'b0;
        o_res.kind        = KIND_PAYLOAD;
        o_res.data_byte   = '0;
        o_res.msg_class   = r_class;
        o_res.msg_id      = r_id;
        o_res.payload_len = r_len;
        o_res.byte_pos    = '0;

        unique case (r_phase)
            PH_SYNC2: begin
                n_phase = (i_byte == SYNC_SECOND) ? PH_CLASS : PH_HUNT;
            end
            PH_CLASS: begin
                // sums restart at the class byte
                n_sum_a = i_byte;
                n_sum_b = i_byte;
                n_class = i_byte;
                n_phase = PH_ID;
            end
            PH_ID: begin
                n_sum_a = acc_a;
                n_sum_b = acc_b;
                n_id    = i_byte;
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_sum_a = acc_a;
                n_sum_b = acc_b;
                n_len   = {8'd0, i_byte};
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_sum_a = acc_a;
                n_sum_b = acc_b;
                n_len   = len_full;
                n_count = '0;
                n_phase = (len_full == 16'd0) ? PH_CK_A : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_sum_a = acc_a;
                n_sum_b = acc_b;
                n_count = count_inc;
                if (count_inc == r_len) begin
                    n_phase = PH_CK_A;
                end
                o_res_vld       = i_fire;
                o_res.data_byte = i_byte;
                o_res.byte_pos  = r_count;
            end
            PH_CK_A: begin
                n_ck_a_ok = (i_byte == r_sum_a);
                n_phase   = PH_CK_B;
            end
            PH_CK_B: begin
                o_res_vld  = i_fire;
                o_res.kind = (r_ck_a_ok && (i_byte == r_sum_b)) ? KIND_GOOD : KIND_BAD;
                n_phase    = PH_HUNT;
            end
            default: begin
                n_phase = (i_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
            end
        endcase
    end

    a_res_needs_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld |-> i_fire)
        else $error("result without an accepted beat");

    a_trailer_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && o_res.kind != KIND_PAYLOAD) |-> r_phase == PH_CK_B)
        else $error("trailer outside checksum phase");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_count < r_len)
        else $error("payload count ran past length");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_phase == PH_PAYLOAD && count_inc != r_len) |=> r_phase == PH_PAYLOAD)
        else $error("payload phase left early");

endmodule

`default_nettype wire

// File: design/sldf_outbuf.sv
`default_nettype none

module sldf_outbuf
    import sldf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_vld,
    input  wire t_result  i_res,
    output logic          o_ready,
    sldf_result_if.source o_out
);

    logic    r_out_vld;
    logic    r_skid_vld;
    t_result r_out;
    t_result r_skid;
    logic    take;

    assign take    = r_out_vld && o_out.ready;
    assign o_ready = !r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (take) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || take) begin
            r_out_vld <= i_vld;
        end else if (i_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    // payload side, no reset
    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_vld || take) begin
            if (i_vld) begin
                r_out <= i_res;
            end
        end else if (i_vld) begin
            r_skid <= i_res;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.result_kind = r_out.kind;
    assign o_out.data_byte   = r_out.data_byte;
    assign o_out.msg_class   = r_out.msg_class;
    assign o_out.msg_id      = r_out.msg_id;
    assign o_out.payload_len = r_out.payload_len;
    assign o_out.byte_pos    = r_out.byte_pos;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds a beat while output stage is empty");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> !i_vld)
        else $error("beat pushed into full buffer");

    a_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_out.ready) |=> r_out_vld)
        else $error("stalled result dropped");

endmodule

`default_nettype wire

// File: design/sync_length_checksum_deframer_unit.sv
`default_nettype none

// Sync/length/Fletcher-8 deframer. Takes one received byte per beat on i_in,
// hunts for the sync pair B5 62, then reads class, id and a little-endian
// 16-bit length. Every payload byte leaves on o_out as a beat with kind
// "payload", tagged with class, id, declared length and its position. After
// the two checksum bytes (A then B, 8-bit Fletcher over class, id, length
// and payload) one trailer beat reports the frame good or bad, and hunting
// resumes with the next byte. A second sync byte other than 62 is dropped.
// Rate: one byte per clock while i_in.ready is high. Each byte is processed
// in the cycle it is accepted; its result beat is registered in a two-deep
// output stage (result register plus skid register) that feeds o_out and
// lets input continue while a result waits; i_in.ready drops only when both
// stages are full, i.e. after two results pile up behind a stalled sink.
module sync_length_checksum_deframer_unit
    import sldf_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    sldf_byte_if.sink     i_in,
    sldf_result_if.source o_out
);

    logic    fire;
    logic    buf_ready;
    logic    res_vld;
    t_result res;

    assign i_in.ready = buf_ready;
    assign fire       = i_in.valid && buf_ready;

    // frame state machine and checksum
    sldf_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_byte    (i_in.in_byte),
        .o_res_vld (res_vld),
        .o_res     (res)
    );

    // result register with skid stage
    sldf_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (res_vld),
        .i_res   (res),
        .o_ready (buf_ready),
        .o_out   (o_out)
    );

    // input stalls only when both output stages hold a beat
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !$past(o_out.ready)))
        else $error("input stalled with room in output stage");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.result_kind == KIND_PAYLOAD ||
                         o_out.result_kind == KIND_GOOD ||
                         o_out.result_kind == KIND_BAD))
        else $error("illegal result kind");

    a_trailer_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.result_kind != KIND_PAYLOAD) |->
            (o_out.data_byte == 8'd0 && o_out.byte_pos == 16'd0))
        else $error("trailer carries payload fields");

endmodule

`default_nettype wire

// File: verif/tb.sv
`default_nettype none

// Testbench for the sync/length/Fletcher-8 deframer.
// A table of short directed frames comes first. Random frames, noise and broken
// sync pairs follow, under four idle/stall mixes, the third with one long sink
// hold-off; one long frame ends the run. Each result beat is checked in order
// against an in-bench model, or a hand-typed result in the directed rows.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sldf_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 11;
    localparam int ITEM_TARGET  = 900;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int MAX_REPORTS  = 10;
    localparam int DIR_ROWS     = 21;
    localparam int LONG_LEN     = 300;

    localparam t_result NO_BEAT = '0;

    // One directed row: the byte, and a result typed in by hand where it is obvious.
    typedef struct packed {
        logic [7:0] byt;
        logic       fixed;
        t_result    want;
    } t_stim_row;

    // Directed stimulus:
    //   B5 B5 62       -> second B5 eaten as a bad second sync byte, 62 then hunted past
    //   frame 1        -> class FF, id 00, empty payload, correct checksum FF FC
    //   frame 2        -> class 00, id FF, payload 00 FF, checksum A right and B wrong
    t_stim_row dir_rows [DIR_ROWS] = '{
        '{8'hB5, 1'b0, NO_BEAT},
        '{8'hB5, 1'b0, NO_BEAT},
        '{8'h62, 1'b0, NO_BEAT},
        '{8'hB5, 1'b0, NO_BEAT},
        '{8'h62, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, NO_BEAT},
        '{8'hFC, 1'b1, '{KIND_GOOD, 8'h00, 8'hFF, 8'h00, 16'h0000, 16'h0000}},
        '{8'hB5, 1'b0, NO_BEAT},
        '{8'h62, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, NO_BEAT},
        '{8'h02, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, NO_BEAT},
        '{8'h00, 1'b1, '{KIND_PAYLOAD, 8'h00, 8'h00, 8'hFF, 16'h0002, 16'h0000}},
        '{8'hFF, 1'b1, '{KIND_PAYLOAD, 8'hFF, 8'h00, 8'hFF, 16'h0002, 16'h0001}},
        '{8'h00, 1'b0, NO_BEAT},
        '{8'h00, 1'b1, '{KIND_BAD, 8'h00, 8'h00, 8'hFF, 16'h0002, 16'h0000}}
    };

    logic clk;
    logic rst_n;

    sldf_byte_if   byte_ch ();
    sldf_result_if res_ch ();

    sync_length_checksum_deframer_unit u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_ch),
        .o_out   (res_ch)
    );

    // Deframer model state.
    logic [3:0]  ph;
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
    logic [7:0]  cur_class;
    logic [7:0]  cur_id;
    logic [15:0] cur_len;
    logic [15:0] pay_cnt;
    logic        ck_a_ok;

    // Result beats predicted but not yet seen on the output.
    t_result awaited_beats [$];

    int bytes_sent;
    int beats_seen;
    int good_frames;
    int bad_frames;
    int mismatches;
    int strays;
    int cycles;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_req;

    // Fletcher-8 update; {B, A} in and out.
    function automatic logic [15:0] fletcher_next(input logic [15:0] ba, input logic [7:0] v);
        logic [7:0] a;
        a = ba[7:0] + v;
        return {ba[15:8] + a, a};
    endfunction

    // Advances the model by one received byte; returns 1 when a beat results.
    function automatic bit deframe_byte(input logic [7:0] b, output t_result beat);
        bit    hit;
        t_kind k;
        hit  = 1'b0;
        beat = NO_BEAT;
        case (ph)
            PH_SYNC2: begin
                ph = (b == SYNC_SECOND) ? PH_CLASS : PH_HUNT;
            end
            PH_CLASS: begin
                {sum_b, sum_a} = fletcher_next(16'h0000, b);
                cur_class = b;
                ph = PH_ID;
            end
            PH_ID: begin
                {sum_b, sum_a} = fletcher_next({sum_b, sum_a}, b);
                cur_id = b;
                ph = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                {sum_b, sum_a} = fletcher_next({sum_b, sum_a}, b);
                cur_len = {8'h00, b};
                ph = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                {sum_b, sum_a} = fletcher_next({sum_b, sum_a}, b);
                cur_len[15:8] = b;
                pay_cnt = 16'h0000;
                // empty payload skips straight to the checksum
                ph = (cur_len == 16'h0000) ? PH_CK_A : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                {sum_b, sum_a} = fletcher_next({sum_b, sum_a}, b);
                beat = '{KIND_PAYLOAD, b, cur_class, cur_id, cur_len, pay_cnt};
                hit = 1'b1;
                pay_cnt = pay_cnt + 16'h0001;
                if (pay_cnt == cur_len) ph = PH_CK_A;
            end
            PH_CK_A: begin
                ck_a_ok = (b == sum_a);
                ph = PH_CK_B;
            end
            PH_CK_B: begin
                if (ck_a_ok && b == sum_b) k = KIND_GOOD;
                else k = KIND_BAD;
                beat = '{k, 8'h00, cur_class, cur_id, cur_len, 16'h0000};
                hit = 1'b1;
                // a bad frame is not rescanned; hunting picks up after it
                ph = PH_HUNT;
            end
            default: begin
                ph = (b == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
            end
        endcase
        return hit;
    endfunction

    // Offers one byte, with a random idle gap first, and returns at its acceptance.
    // The expectation is queued as soon as the byte is offered, ahead of any result.
    task automatic offer_byte(input logic [7:0] b, input logic fixed, input t_result want);
        t_result beat;
        if ($urandom_range(99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= b;
        if (deframe_byte(b, beat) || fixed) awaited_beats.push_back(fixed ? want : beat);
        bytes_sent++;
        do @(posedge clk); while (byte_ch.ready !== 1'b1);
    endtask

    // Source goes quiet until every predicted beat has come out.
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        do @(posedge clk); while (awaited_beats.size() != 0);
    endtask

    // Whole frame with random class, id and payload.
    // corrupt bit 0 spoils checksum A, bit 1 spoils checksum B.
    task automatic send_frame(input int len, input int corrupt);
        logic [15:0] ba;
        logic [7:0]  hdr [4];
        logic [7:0]  v;
        hdr[0] = 8'($urandom);
        hdr[1] = 8'($urandom);
        hdr[2] = len[7:0];
        hdr[3] = len[15:8];
        offer_byte(SYNC_FIRST, 1'b0, NO_BEAT);
        offer_byte(SYNC_SECOND, 1'b0, NO_BEAT);
        ba = 16'h0000;
        for (int i = 0; i < 4; i++) begin
            ba = fletcher_next(ba, hdr[i]);
            offer_byte(hdr[i], 1'b0, NO_BEAT);
        end
        for (int i = 0; i < len; i++) begin
            // sync bytes and extremes inside the payload must pass straight through
            case ($urandom_range(11))
                0:       v = SYNC_FIRST;
                1:       v = SYNC_SECOND;
                2:       v = 8'h00;
                3:       v = 8'hFF;
                default: v = 8'($urandom);
            endcase
            ba = fletcher_next(ba, v);
            offer_byte(v, 1'b0, NO_BEAT);
        end
        v = ba[7:0];
        if (corrupt[0]) v = v ^ (8'h01 << $urandom_range(7));
        offer_byte(v, 1'b0, NO_BEAT);
        v = ba[15:8];
        if (corrupt[1]) v = v ^ (8'h01 << $urandom_range(7));
        offer_byte(v, 1'b0, NO_BEAT);
    endtask

    // One random piece of traffic. Every piece leaves the deframer hunting again.
    task automatic random_chunk();
        int         pick;
        int         n;
        logic [7:0] v;
        pick = $urandom_range(99);
        if (pick < 8) begin
            // line noise; B5 kept out so no partial sync leaks into the next piece
            n = $urandom_range(1, 6);
            repeat (n) begin
                v = 8'($urandom);
                if (v == SYNC_FIRST) v = 8'h00;
                offer_byte(v, 1'b0, NO_BEAT);
            end
        end else if (pick < 14) begin
            // broken sync pair; the second byte is dropped, B5 included
            v = 8'($urandom);
            if (v == SYNC_SECOND) v = SYNC_FIRST;
            offer_byte(SYNC_FIRST, 1'b0, NO_BEAT);
            offer_byte(v, 1'b0, NO_BEAT);
        end else begin
            if (pick == 14) n = $urandom_range(256, 400);
            else if (pick < 22) n = 0;
            else n = $urandom_range(1, 12);
            send_frame(n, ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Sink side: random stalls, or one long hold-off when asked for.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Result checker: each beat against the oldest prediction, field by field.
    always @(posedge clk) begin
        t_result want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            beats_seen++;
            if (res_ch.result_kind == KIND_GOOD) good_frames++;
            else if (res_ch.result_kind == KIND_BAD) bad_frames++;
            if (awaited_beats.size() == 0) begin
                strays++;
                if (mismatches + strays <= MAX_REPORTS)
                    $display("unexpected beat: kind=%0d data=%h class=%h id=%h len=%0d pos=%0d",
                             res_ch.result_kind, res_ch.data_byte, res_ch.msg_class,
                             res_ch.msg_id, res_ch.payload_len, res_ch.byte_pos);
            end else begin
                want = awaited_beats.pop_front();
                if (want.kind !== res_ch.result_kind || want.data_byte !== res_ch.data_byte ||
                    want.msg_class !== res_ch.msg_class || want.msg_id !== res_ch.msg_id ||
                    want.payload_len !== res_ch.payload_len ||
                    want.byte_pos !== res_ch.byte_pos) begin
                    mismatches++;
                    if (mismatches + strays <= MAX_REPORTS) begin
                        $display("mismatch at beat %0d: exp kind=%0d data=%h class=%h id=%h len=%0d pos=%0d",
                                 beats_seen, want.kind, want.data_byte, want.msg_class,
                                 want.msg_id, want.payload_len, want.byte_pos);
                        $display("                     got kind=%0d data=%h class=%h id=%h len=%0d pos=%0d",
                                 res_ch.result_kind, res_ch.data_byte, res_ch.msg_class,
                                 res_ch.msg_id, res_ch.payload_len, res_ch.byte_pos);
                    end
                end
            end
        end
    end

    // Watchdog.
    initial begin
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("no progress within %0d cycles, %0d beats still awaited",
                 CYCLE_LIMIT, awaited_beats.size());
        $display("simulation failed");
        $finish;
    end

    initial begin
        int mode;
        rst_n           = 1'b0;
        byte_ch.valid   = 1'b0;
        byte_ch.in_byte = 8'h00;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_req        = 1'b0;
        bytes_sent      = 0;
        beats_seen      = 0;
        good_frames     = 0;
        bad_frames      = 0;
        mismatches      = 0;
        strays          = 0;
        ph              = PH_HUNT;
        sum_a           = 8'h00;
        sum_b           = 8'h00;
        cur_class       = 8'h00;
        cur_id          = 8'h00;
        cur_len         = 16'h0000;
        pay_cnt         = 16'h0000;
        ck_a_ok         = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
            offer_byte(dir_rows[r].byt, dir_rows[r].fixed, dir_rows[r].want);
        wait_drained();

        // Four traffic mixes, roughly a quarter of the random bytes each.
        for (mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            if (mode == 2) begin
                // sink holds off while a back-to-back frame fills the output stage
                // and backs up the input; then the source waits for every beat
                hold_req = 1'b1;
                send_frame(40, 0);
                wait_drained();
            end
            while (bytes_sent < DIR_ROWS + (mode + 1) * (ITEM_TARGET - LONG_LEN) / 4)
                random_chunk();
        end

        // long frame, byte_pos well past one byte
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_frame(LONG_LEN, 0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d bytes: directed frames, noise, broken syncs, four idle/stall mixes,",
                 bytes_sent);
        $display("a %0d-cycle sink hold-off and a %0d-byte frame; %0d beats (%0d good, %0d bad)",
                 HOLD_CYCLES, LONG_LEN, beats_seen, good_frames, bad_frames);
        if (mismatches == 0 && strays == 0 && awaited_beats.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d unexpected beats, %0d beats missing",
                     mismatches, strays, awaited_beats.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
design/sldf_pkg.sv
design/sldf_byte_if.sv
design/sldf_result_if.sv
design/sldf_parser.sv
design/sldf_outbuf.sv
design/sync_length_checksum_deframer_unit.sv
verif/tb.sv
